[hw/rtl/tecs_pkg.sv]
// ----------------------------------------------------------------------------
// tecs_pkg: shared definitions for the typed element convert stage
// Conversion mode codes and binary32/binary16 field constants.
// ----------------------------------------------------------------------------
package tecs_pkg;

  // conversion selected per transaction
  typedef enum logic [1:0] {
    MODE_NARROW  = 2'd0,  // binary32 -> binary16, round to nearest even
    MODE_WIDEN   = 2'd1,  // binary16 -> binary32, exact
    MODE_QUANT   = 2'd2,  // binary32 * inverse scale -> s8
    MODE_DEQUANT = 2'd3   // (s8 - zero point) * scale -> binary32
  } mode_t;

  localparam logic [7:0]  F32_EXP_MAX    = 8'hff;
  localparam logic [31:0] F32_QNAN_DFLT  = 32'hffc0_0000;
  localparam logic [31:0] F32_QUIET_BIT  = 32'h0040_0000;
  localparam logic [30:0] F32_INF_MAG    = 31'h7f80_0000;
  localparam logic [14:0] F16_INF_MAG    = 15'h7c00;
  localparam logic [14:0] F16_QNAN_MAG   = 15'h7e00;
  localparam logic [7:0]  S8_MAX         = 8'h7f;
  localparam logic [7:0]  S8_MIN         = 8'h80;
  // exponent that a small integer operand gets when its magnitude sits
  // in the low bits of a 24-bit significand
  localparam logic [7:0]  INT_EXP        = 8'd150;

endpackage

[hw/rtl/typed_element_convert_stage_unit.sv]
// ----------------------------------------------------------------------------
// typed_element_convert_stage_unit: per-element type conversion pipeline
// Six register stages: unpack/convert, multiply, leading-zero count,
// align, round, quantize/output.
// ----------------------------------------------------------------------------
// Each transaction carries one element and a mode: binary32 to binary16
// (round to nearest even), binary16 to binary32, quantize binary32 to s8
// (one binary32 product with the inverse scale, rounded to nearest even and
// saturated, NaN gives 0), or dequantize s8 ((byte - zero point) * scale as
// one binary32 multiply). A new transaction is taken every cycle while the
// output is not stalled; each result passes through every stage register. The
// whole pipeline holds while the output is stalled, so src_stall follows
// dst_stall whenever a result is waiting at the output register. Quantize and
// dequantize share one 24x24 significand multiplier in stage two.
module typed_element_convert_stage_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  logic [1:0]        mode,
  input  logic [31:0]       value_bits,
  input  logic [31:0]       scale_value,
  input  logic signed [7:0] zero_point,
  output logic              dst_valid,
  input  logic              dst_stall,
  output logic [31:0]       result_bits
);
  import tecs_pkg::*;

  logic adv;
  assign adv       = !(dst_valid && dst_stall);
  assign src_stall = !adv;

  // ---------------- stage 1: unpack operands, direct conversions -----------
  logic        v1;
  logic        q1;          // quantize item
  logic        alt1;        // result already known
  logic [31:0] alt_bits1;
  logic        s1;
  logic [7:0]  ea1, eb1;
  logic [23:0] ma1, mb1;

  logic [31:0] narrow_res, widen_res, spec_bits, alt_bits_next;
  logic        spec, alt_next, sa, sb;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [8:0]  dq_diff;
  logic [7:0]  dq_mag;

  // binary32 -> binary16
  always_comb begin
    logic        ns;
    logic [7:0]  nex;
    logic [22:0] nman;
    logic [14:0] h;
    logic        up;
    logic [23:0] full;
    logic [6:0]  shift;
    logic [48:0] ext;
    ns   = value_bits[31];
    nex  = value_bits[30:23];
    nman = value_bits[22:0];
    h    = '0;
    up   = 1'b0;
    full = '0;
    shift = '0;
    ext  = '0;
    if (nex == F32_EXP_MAX) begin
      h = (nman != '0) ? (F16_QNAN_MAG | {5'd0, nman[22:13]}) : F16_INF_MAG;
    end else if (nex >= 8'd143) begin
      h = F16_INF_MAG;
    end else if (nex >= 8'd113) begin
      h  = {5'(nex - 8'd112), nman[22:13]};
      up = nman[12] && ((nman[11:0] != '0) || h[0]);
      h  = h + 15'(up);
    end else begin
      // binary16 subnormal or zero
      full  = {(nex != '0), nman};
      shift = 7'(8'd126 - nex);
      if (shift < 7'd25) begin
        ext = {full, 25'd0} >> shift[4:0];
        up  = ext[24] && ((ext[23:0] != '0) || ext[25]);
        h   = 15'(ext[48:25]) + 15'(up);
      end
    end
    narrow_res = {16'd0, ns, h};
  end

  // binary16 -> binary32
  always_comb begin
    logic        ws;
    logic [4:0]  wex;
    logic [9:0]  wman;
    logic [3:0]  lz;
    logic [10:0] sh;
    ws   = value_bits[15];
    wex  = value_bits[14:10];
    wman = value_bits[9:0];
    lz   = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (wman[i]) lz = 4'(9 - i);
    end
    sh = {1'b0, wman} << (lz + 4'd1);
    if (wex == 5'h1f) begin
      widen_res = (wman != '0) ? ({ws, 31'h7fc0_0000} | {9'd0, wman, 13'd0})
                               : {ws, F32_INF_MAG};
    end else if (wex == '0) begin
      widen_res = (wman == '0) ? {ws, 31'd0}
                               : {ws, 8'(8'd112 - {4'd0, lz}), sh[9:0], 13'd0};
    end else begin
      widen_res = {ws, 8'({3'd0, wex} + 8'd112), wman, 13'd0};
    end
  end

  // multiplier operands
  always_comb begin
    dq_diff = 9'($signed({value_bits[7], value_bits[7:0]})
                 - $signed({zero_point[7], zero_point}));
    dq_mag  = dq_diff[8] ? 8'(-dq_diff) : dq_diff[7:0];
    if (mode_t'(mode) == MODE_DEQUANT) begin
      sa     = dq_diff[8];
      ea     = INT_EXP;
      ma     = {16'd0, dq_mag};
      a_nan  = 1'b0;
      a_inf  = 1'b0;
      a_zero = (dq_mag == '0);
    end else begin
      sa     = value_bits[31];
      ea     = (value_bits[30:23] == '0) ? 8'd1 : value_bits[30:23];
      ma     = {(value_bits[30:23] != '0), value_bits[22:0]};
      a_nan  = (value_bits[30:23] == F32_EXP_MAX) && (value_bits[22:0] != '0);
      a_inf  = (value_bits[30:23] == F32_EXP_MAX) && (value_bits[22:0] == '0);
      a_zero = (value_bits[30:0] == '0);
    end
    sb     = scale_value[31];
    eb     = (scale_value[30:23] == '0) ? 8'd1 : scale_value[30:23];
    mb     = {(scale_value[30:23] != '0), scale_value[22:0]};
    b_nan  = (scale_value[30:23] == F32_EXP_MAX) && (scale_value[22:0] != '0);
    b_inf  = (scale_value[30:23] == F32_EXP_MAX) && (scale_value[22:0] == '0);
    b_zero = (scale_value[30:0] == '0);
  end

  // product special cases, first operand NaN wins
  always_comb begin
    spec = 1'b1;
    if (a_nan) begin
      spec_bits = value_bits | F32_QUIET_BIT;
    end else if (b_nan) begin
      spec_bits = scale_value | F32_QUIET_BIT;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_bits = F32_QNAN_DFLT;
    end else if (a_inf || b_inf) begin
      spec_bits = {sa ^ sb, F32_INF_MAG};
    end else if (a_zero || b_zero) begin
      spec_bits = {sa ^ sb, 31'd0};
    end else begin
      spec      = 1'b0;
      spec_bits = '0;
    end
  end

  always_comb begin
    unique case (mode_t'(mode))
      MODE_NARROW: begin
        alt_next      = 1'b1;
        alt_bits_next = narrow_res;
      end
      MODE_WIDEN: begin
        alt_next      = 1'b1;
        alt_bits_next = widen_res;
      end
      default: begin
        alt_next      = spec;
        alt_bits_next = spec_bits;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= src_valid;
    end
    if (adv) begin
      q1        <= (mode_t'(mode) == MODE_QUANT);
      alt1      <= alt_next;
      alt_bits1 <= alt_bits_next;
      s1        <= sa ^ sb;
      ea1       <= ea;
      eb1       <= eb;
      ma1       <= ma;
      mb1       <= mb;
    end
  end

  // ---------------- stage 2: significand multiply --------------------------
  logic        v2, q2, alt2, s2;
  logic [31:0] alt_bits2;
  logic [47:0] p2;
  logic [8:0]  esum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      q2        <= q1;
      alt2      <= alt1;
      alt_bits2 <= alt_bits1;
      s2        <= s1;
      p2        <= ma1 * mb1;
      esum2     <= {1'b0, ea1} + {1'b0, eb1};
    end
  end

  // ---------------- stage 3: leading-zero count, exponent ------------------
  logic        v3, q3, alt3, s3;
  logic [31:0] alt_bits3;
  logic [47:0] p3;
  logic [5:0]  lz3;
  logic signed [10:0] e3;
  logic [5:0]  lz_next;

  always_comb begin
    lz_next = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (p2[i]) lz_next = 6'(47 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      q3        <= q2;
      alt3      <= alt2;
      alt_bits3 <= alt_bits2;
      s3        <= s2;
      p3        <= p2;
      lz3       <= lz_next;
      e3        <= $signed({2'b0, esum2}) - 11'sd126 - $signed({5'd0, lz_next});
    end
  end

  // ---------------- stage 4: normalize / denormalize shift -----------------
  logic        v4, q4, alt4, s4, sticky4;
  logic [31:0] alt_bits4;
  logic [47:0] n4;
  logic [9:0]  expf4;

  logic [5:0]  shl;
  logic [5:0]  shr;
  logic [95:0] ext4;
  always_comb begin
    logic signed [10:0] r;
    logic signed [10:0] net;
    r   = 11'sd1 - e3;
    net = $signed({5'd0, lz3}) - r;
    if (e3 >= 11'sd1) begin
      shl = lz3;
      shr = '0;
    end else if (net >= 11'sd0) begin
      shl = net[5:0];
      shr = '0;
    end else begin
      shl = '0;
      shr = (-net > 11'sd63) ? 6'd63 : 6'(-net);
    end
    ext4 = {p3 << shl, 48'd0} >> shr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      q4        <= q3;
      alt4      <= alt3;
      alt_bits4 <= alt_bits3;
      s4        <= s3;
      n4        <= ext4[95:48];
      sticky4   <= (ext4[47:0] != '0);
      expf4     <= (e3 >= 11'sd1) ? e3[9:0] : 10'd0;
    end
  end

  // ---------------- stage 5: round and pack binary32 -----------------------
  logic        v5, q5;
  logic [31:0] f5;
  logic [31:0] f_next;

  always_comb begin
    logic        up;
    logic [32:0] sum;
    up  = n4[23] && (n4[24] || (n4[22:0] != '0) || sticky4);
    sum = {expf4, n4[46:24]} + 33'(up);
    if (alt4) begin
      f_next = alt_bits4;
    end else if (sum[32:23] >= 10'd255) begin
      f_next = {s4, F32_INF_MAG};
    end else begin
      f_next = {s4, sum[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      q5 <= q4;
      f5 <= f_next;
    end
  end

  // ---------------- stage 6: quantize, output register ---------------------
  logic [7:0] q_byte;
  always_comb begin
    logic [7:0]  fe;
    logic [23:0] fm;
    logic [4:0]  sh;
    logic [47:0] ext;
    logic [8:0]  mag;
    logic        up;
    fe  = f5[30:23];
    fm  = {1'b1, f5[22:0]};
    sh  = '0;
    ext = '0;
    mag = '0;
    up  = 1'b0;
    if (fe == F32_EXP_MAX && f5[22:0] != '0) begin
      q_byte = '0;
    end else if (fe >= 8'd135) begin
      q_byte = f5[31] ? S8_MIN : S8_MAX;
    end else begin
      if (fe >= 8'd126) begin
        sh  = 5'(8'd150 - fe);
        ext = {fm, 24'd0} >> sh;
        up  = ext[23] && ((ext[22:0] != '0) || ext[24]);
        mag = ext[32:24] + 9'(up);
      end
      if (f5[31]) begin
        q_byte = (mag >= 9'd128) ? S8_MIN : 8'(-mag);
      end else begin
        q_byte = (mag >= 9'd127) ? S8_MAX : mag[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (adv) begin
      dst_valid <= v5;
    end
    if (adv) begin
      result_bits <= q5 ? {24'd0, q_byte} : f5;
    end
  end

endmodule

[tb/typed_element_convert_stage_unit_chk.sv]
// ----------------------------------------------------------------------------
// typed_element_convert_stage_unit_chk: result checker for the convert stage
// Watches both channels, predicts each result from the accepted transaction
// with bit-exact integer float arithmetic and compares in arrival order.
// ----------------------------------------------------------------------------
module typed_element_convert_stage_unit_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  input  logic              src_stall,
  input  logic [1:0]        mode,
  input  logic [31:0]       value_bits,
  input  logic [31:0]       scale_value,
  input  logic signed [7:0] zero_point,
  input  logic              dst_valid,
  input  logic              dst_stall,
  input  logic [31:0]       result_bits,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tecs_pkg::*;

  logic [31:0] expected_results[$];

  // binary32 -> binary16, round to nearest even
  function automatic logic [31:0] f32_to_f16(logic [31:0] b);
    logic [31:0] sgn, man, h, rest, half, full;
    int          ex, he, sh;
    sgn = {16'd0, b[31], 15'd0};
    ex  = b[30:23];
    man = {9'd0, b[22:0]};
    if (ex == F32_EXP_MAX) begin
      if (man != 0) return sgn | {17'd0, F16_QNAN_MAG} | (man >> 13);
      return sgn | {17'd0, F16_INF_MAG};
    end
    he = ex - 112;
    if (he >= 31) return sgn | {17'd0, F16_INF_MAG};
    if (he >= 1) begin
      h    = (he << 10) | (man >> 13);
      rest = man & 32'h1fff;
      if (rest > 32'h1000 || (rest == 32'h1000 && h[0])) h++;
      return sgn | h;
    end
    full = (ex == 0) ? man : (man | 32'h0080_0000);
    sh   = 14 - he;
    if (sh >= 25) return sgn;
    h    = full >> sh;
    rest = full & ((32'd1 << sh) - 1);
    half = 32'd1 << (sh - 1);
    if (rest > half || (rest == half && h[0])) h++;
    return sgn | h;
  endfunction

  // binary16 -> binary32, exact
  function automatic logic [31:0] f16_to_f32(logic [15:0] hb);
    logic [31:0] sgn, man;
    int          ex, e32;
    sgn = {hb[15], 31'd0};
    ex  = hb[14:10];
    man = {22'd0, hb[9:0]};
    if (ex == 31) begin
      if (man != 0) return sgn | 32'h7fc0_0000 | (man << 13);
      return sgn | {1'b0, F32_INF_MAG};
    end
    if (ex == 0) begin
      if (man == 0) return sgn;
      e32 = 113;
      while (man[10] == 1'b0) begin
        man = man << 1;
        e32--;
      end
      man = man & 32'h3ff;
      return sgn | (e32 << 23) | (man << 13);
    end
    return sgn | ((ex + 112) << 23) | (man << 13);
  endfunction

  // binary32 product, round to nearest even, subnormals kept
  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [63:0] p, q, rest, half;
    int          ea, eb, er, msb, sh;
    sgn = a[31] ^ b[31];
    if (a[30:23] == F32_EXP_MAX && a[22:0] != 0) return a | F32_QUIET_BIT;
    if (b[30:23] == F32_EXP_MAX && b[22:0] != 0) return b | F32_QUIET_BIT;
    if (a[30:23] == F32_EXP_MAX || b[30:23] == F32_EXP_MAX) begin
      if (a[30:0] == 0 || b[30:0] == 0) return F32_QNAN_DFLT;
      return {sgn, F32_INF_MAG};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    p  = {40'd0, (a[30:23] != 0), a[22:0]} * {40'd0, (b[30:23] != 0), b[22:0]};
    msb = 0;
    for (int i = 0; i < 48; i++) if (p[i]) msb = i;
    er = msb + ea + eb - 173;
    if (er >= 255) return {sgn, F32_INF_MAG};
    sh = (er >= 1) ? msb - 23 : 151 - ea - eb;
    if (sh >= 60) return {sgn, 31'd0};
    if (sh <= 0) q = p << (-sh);
    else begin
      q    = p >> sh;
      rest = p & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && q[0])) q++;
    end
    // hidden bit carries into the exponent field
    if (er >= 1) q = q + ((er - 1) << 23);
    if (q >= 64'h7f80_0000) return {sgn, F32_INF_MAG};
    return {sgn, q[30:0]};
  endfunction

  // quantize: product rounded to nearest even, saturated, NaN gives 0
  function automatic logic [31:0] quantize_byte(logic [31:0] x, logic [31:0] s);
    logic [31:0] p, k, rest, half, sig;
    int          e, sh;
    p = f32_mul(x, s);
    e = p[30:23];
    if (e == F32_EXP_MAX && p[22:0] != 0) return 0;
    if (e >= 134) return p[31] ? {24'd0, S8_MIN} : {24'd0, S8_MAX};
    if (e < 126) k = 0;
    else begin
      sig  = {8'd1, p[22:0]};
      sh   = 150 - e;
      k    = sig >> sh;
      rest = sig & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      if (rest > half || (rest == half && k[0])) k++;
    end
    if (!p[31]) return (k > 127) ? {24'd0, S8_MAX} : k;
    return (0 - k) & 32'hff;
  endfunction

  // small integer to binary32, exact
  function automatic logic [31:0] int_to_f32(int d);
    logic [31:0] m;
    int          msb;
    if (d == 0) return 0;
    m = (d < 0) ? -d : d;
    msb = 0;
    for (int i = 0; i < 31; i++) if (m[i]) msb = i;
    return {(d < 0), 8'(127 + msb), 23'((m << (23 - msb)) & 32'h7f_ffff)};
  endfunction

  function automatic logic [31:0] convert_element(mode_t m, logic [31:0] v,
                                                  logic [31:0] s, logic signed [7:0] z);
    case (m)
      MODE_NARROW: return f32_to_f16(v);
      MODE_WIDEN:  return f16_to_f32(v[15:0]);
      MODE_QUANT:  return quantize_byte(v, s);
      default:     return f32_mul(int_to_f32(int'($signed(v[7:0])) - int'(z)), s);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    fails++;
  endtask

  assign pending = expected_results.size();

  initial fails = 0;

  // predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if (src_valid && !src_stall)
        expected_results = {expected_results,
                            convert_element(mode_t'(mode), value_bits,
                                            scale_value, zero_point)};
      if (dst_valid && !dst_stall) begin
        if (expected_results.size() == 0)
          report_mismatch($sformatf("unexpected result %h", result_bits));
        else begin
          want = expected_results.pop_front();
          if (want !== result_bits)
            report_mismatch($sformatf("result_bits got %h want %h", result_bits, want));
        end
      end
    end
  end
endmodule

[tb/typed_element_convert_stage_unit_tb.sv]
// ----------------------------------------------------------------------------
// typed_element_convert_stage_unit_tb: stimulus and verdict for the stage
// Drives directed corner elements for all four modes, then random ones with
// random gaps and output stalls; the checker does all comparison.
// ----------------------------------------------------------------------------
module typed_element_convert_stage_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tecs_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_stall;
  logic [1:0]        mode = MODE_NARROW;
  logic [31:0]       value_bits = '0;
  logic [31:0]       scale_value = '0;
  logic signed [7:0] zero_point = '0;
  logic              dst_valid;
  logic              dst_stall = 1'b0;
  logic [31:0]       result_bits;
  int                fails, pending;
  int                cycles = 0;
  int                max_gap = 14;
  int                max_hold = 14;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typed_element_convert_stage_unit DUT (.*);

  typed_element_convert_stage_unit_chk u_chk (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output side: random stall before each result
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(0, max_hold);
      if (n > 0) begin
        dst_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      dst_stall <= 1'b0;
      do @(posedge clk); while (!(dst_valid && !dst_stall));
    end
  end

  task automatic send_element(mode_t m, logic [31:0] v, logic [31:0] s, logic [7:0] z);
    int n;
    n = $urandom_range(0, max_gap);
    if (n > 0) begin
      src_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    src_valid   <= 1'b1;
    mode        <= m;
    value_bits  <= v;
    scale_value <= s;
    zero_point  <= z;
    do @(posedge clk); while (!(src_valid && !src_stall));
  endtask

  // random binary32 with exponent field in [lo, hi]
  function automatic logic [31:0] rand_f32(int lo, int hi);
    return {1'($urandom), 8'($urandom_range(lo, hi)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return rand_f32(100, 145);
      2: return rand_f32(0, 3);
      3: return {1'($urandom), 8'hff, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
      4: return {1'($urandom), 31'($urandom_range(0, 3))};
      default: return rand_f32(120, 134);
    endcase
  endfunction

  initial begin
    logic [31:0] v, s;
    mode_t       m;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: narrowing
    send_element(MODE_NARROW, 32'h0000_0000, '0, '0);
    send_element(MODE_NARROW, 32'hff80_0000, '0, '0);
    send_element(MODE_NARROW, 32'h7fa0_0001, '0, '0);
    send_element(MODE_NARROW, 32'h477f_efff, '0, '0);
    send_element(MODE_NARROW, 32'h477f_f000, '0, '0);
    send_element(MODE_NARROW, 32'h3300_0000, '0, '0);
    send_element(MODE_NARROW, 32'hb300_0001, '0, '0);
    send_element(MODE_NARROW, 32'h3f80_1000, '0, '0);
    send_element(MODE_NARROW, 32'h3880_2000, '0, '0);
    // widening, upper bits ignored
    send_element(MODE_WIDEN, 32'hffff_0001, 32'hffff_ffff, 8'hff);
    send_element(MODE_WIDEN, 32'h0000_83ff, '0, '0);
    send_element(MODE_WIDEN, 32'h1234_fd01, '0, '0);
    send_element(MODE_WIDEN, 32'h0000_7c00, '0, '0);
    // quantize: NaN, zero times infinity, ties, saturation
    send_element(MODE_QUANT, 32'h7fc0_0001, 32'h3f80_0000, '0);
    send_element(MODE_QUANT, 32'h0000_0000, 32'h7f80_0000, '0);
    send_element(MODE_QUANT, 32'h42ff_0000, 32'h3f80_0000, '0);
    send_element(MODE_QUANT, 32'hc301_0000, 32'h3f80_0000, '0);
    send_element(MODE_QUANT, 32'h4020_0000, 32'h3f80_0000, '0);
    send_element(MODE_QUANT, 32'hc020_0000, 32'h3f80_0000, '0);
    send_element(MODE_QUANT, 32'h3f00_0000, 32'hbfc0_0000, '0);
    // dequantize: extremes, NaN scale, infinite scale with zero difference
    send_element(MODE_DEQUANT, 32'hffff_ff80, 32'h3f80_0000, 8'h7f);
    send_element(MODE_DEQUANT, 32'h0000_007f, 32'h7f7f_ffff, 8'h80);
    send_element(MODE_DEQUANT, 32'h0000_0005, 32'h7f80_0000, 8'h05);
    send_element(MODE_DEQUANT, 32'h0000_0003, 32'hff80_0001, 8'h00);
    send_element(MODE_DEQUANT, 32'h0000_0001, 32'h0000_0001, 8'hff);
    // subnormal operand whose product lands exactly on a normal exponent
    send_element(MODE_QUANT, 32'h0000_0001, 32'h4b80_0000, '0);

    // drain once before the random part
    max_gap = 0;
    src_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    for (int i = 0; i < 1650; i++) begin
      // switch idling style every hundred transactions, some phases burst
      if (i % 100 == 0) begin
        max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 14;
        max_hold = ($urandom_range(0, 3) == 0) ? 0 : 14;
      end
      m = mode_t'($urandom_range(0, 3));
      v = rand_operand();
      s = rand_operand();
      if (m == MODE_QUANT && $urandom_range(0, 2) != 0) begin
        v = rand_f32(118, 134);
        s = rand_f32(120, 130);
      end
      send_element(m, v, s, 8'($urandom));
    end

    src_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
